/* design/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Operation and status codes, and the command and status bundles that pass
// between the sorted list controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

   // operation codes carried on req_op
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DEL_VAL = 2'd1;
   localparam logic [1:0] OP_DEL_POS = 2'd2;
   localparam logic [1:0] OP_DUMP    = 2'd3;

   // result status codes carried on rsp_status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_POS   = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic apply;      // an item is accepted this cycle: carry out its operation
      logic dump_step;  // load the next dumped entry into the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero; // store holds no entry
      logic dump_last;  // the entry at the dump index is the final one
   } dp_stat_type;

endpackage

`default_nettype wire

/* design/sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted store of up to DEPTH signed 32-bit values with insert, delete by
// value, delete by position and dump operations.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  req      | req_valid, req_ready, req_op, req_value,     | in
//           | req_position                                 |
//  rsp      | rsp_valid, rsp_ready, rsp_status,            | out
//           | rsp_item_value, rsp_last, rsp_entry_count    |
//
//  Inserts and deletes act on all cells at once: each compares its entry
//  to the incoming value, or its index to the position, and shifts in the
//  same edge. A dump streams one entry per cycle, unless rsp stalls, through
//  the shared read port of the cell row; no item is accepted meanwhile.
//  A result sits in an output register; the next item is taken in the same
//  cycle as the pending result is taken, so a stalled rsp side holds req.
//  Synchronous reset empties the store; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine #(
   parameter int DEPTH = 16
) (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_op,
   input  wire  signed [31:0] req_value,
   input  wire  [7:0]         req_position,
   // result channel
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_item_value,
   output logic               rsp_last,
   output logic [4:0]         rsp_entry_count
);

   sle_pkg::dp_cmd_type  dp_cmd;
   sle_pkg::dp_stat_type dp_stat;

   // controller: hold the handshake, step the dump
   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // datapath: compare-and-shift cells, fill count and result register
   sle_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_status      (rsp_status),
      .rsp_item_value  (rsp_item_value),
      .rsp_last        (rsp_last),
      .rsp_entry_count (rsp_entry_count)
   );

`ifndef SYNTH
   // an accepted single-result operation loads its result, marked last, into the output register
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op != sle_pkg::OP_DUMP))
      |=> (rsp_valid && rsp_last))
      else $error("single-result item did not produce a last result");

   // while a dump is still streaming no new item is taken
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("item accepted in the middle of a dump");

   // an empty status always reports an empty store
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sle_pkg::ST_EMPTY)) |-> (rsp_entry_count == 5'd0))
      else $error("empty status with non-zero entry count");

   // the controller never applies an item and steps a dump together
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.dump_step |-> (!req_ready && !dp_cmd.apply))
      else $error("dump step overlaps an accepted item");
`endif

endmodule

`default_nettype wire

/* design/sle_datapath.sv */
// ----------------------------------------------------------------------------
// sle_datapath
// Row of compare-and-shift cells holding the sorted entries, the fill count,
// the dump index and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath #(
   parameter int DEPTH = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [1:0]          req_op,
   input  wire  signed [31:0]  req_value,
   input  wire  [7:0]          req_position,
   input  wire  sle_pkg::dp_cmd_type cmd,
   output sle_pkg::dp_stat_type stat,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_item_value,
   output logic                rsp_last,
   output logic [4:0]          rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0] entry_ff [DEPTH];
   logic signed [31:0] entry_in [DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      dump_idx_ff, dump_idx_in;

   logic [2:0]         status_ff, status_in;
   logic signed [31:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic [4:0]         ecount_ff, ecount_in;

   logic [DEPTH-1:0]   lt, eq, pos_after, ins_first;
   logic               full, found, bad_pos, load_out;
   logic               do_ins, do_delv, do_delp;
   logic [IW-1:0]      rd_idx;
   logic signed [31:0] rd_data;

   assign full    = (count_ff == CW'(DEPTH));
   assign found   = |eq;
   assign bad_pos = (req_position == 8'd0) || (req_position > 8'(count_ff));

   // one shared read port: the dump index, or the position being removed
   assign rd_idx  = cmd.dump_step ? dump_idx_ff : IW'(req_position - 8'd1);
   assign rd_data = entry_ff[rd_idx];

   assign do_ins  = cmd.apply && (req_op == sle_pkg::OP_INSERT) && !full;
   assign do_delv = cmd.apply && (req_op == sle_pkg::OP_DEL_VAL) && found;
   assign do_delp = cmd.apply && (req_op == sle_pkg::OP_DEL_POS)
                    && (count_ff != '0) && !bad_pos;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] prev_val, next_val;
      logic               in_use;

      assign in_use       = (CW'(i) < count_ff);
      assign lt[i]        = in_use && (entry_ff[i] < req_value);
      assign eq[i]        = in_use && (entry_ff[i] == req_value);
      assign pos_after[i] = (req_position <= 8'(i + 1));

      if (i == 0) begin : g_head
         assign prev_val     = req_value;
         assign ins_first[i] = 1'b1;
      end else begin : g_body
         assign prev_val     = entry_ff[i-1];
         assign ins_first[i] = lt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_val = entry_ff[i];
      end else begin : g_inner
         assign next_val = entry_ff[i+1];
      end

      // keep below the slot, take the new value at it, shift up or down past it
      assign entry_in[i] = (do_ins && !lt[i])  ? (ins_first[i] ? req_value : prev_val) :
                           ((do_delv && !lt[i]) || (do_delp && pos_after[i])) ? next_val :
                           entry_ff[i];
   end

   always_comb begin
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      load_out    = 1'b0;
      if (cmd.apply) begin
         dump_idx_in = '0;
         last_in     = 1'b1;
         load_out    = 1'b1;
         unique case (req_op)
            sle_pkg::OP_INSERT: begin
               value_in = req_value;
               if (full) begin
                  status_in = sle_pkg::ST_FULL;
               end else begin
                  status_in = sle_pkg::ST_OK;
                  count_in  = count_ff + 1'b1;
               end
            end
            sle_pkg::OP_DEL_VAL: begin
               value_in = req_value;
               if (count_ff == '0) begin
                  status_in = sle_pkg::ST_EMPTY;
               end else if (found) begin
                  status_in = sle_pkg::ST_OK;
                  count_in  = count_ff - 1'b1;
               end else begin
                  status_in = sle_pkg::ST_NOT_FOUND;
               end
            end
            sle_pkg::OP_DEL_POS: begin
               value_in = '0;
               if (count_ff == '0) begin
                  status_in = sle_pkg::ST_EMPTY;
               end else if (bad_pos) begin
                  status_in = sle_pkg::ST_BAD_POS;
               end else begin
                  status_in = sle_pkg::ST_OK;
                  value_in  = rd_data;
                  count_in  = count_ff - 1'b1;
               end
            end
            sle_pkg::OP_DUMP: begin
               // only an empty store gives a result straight away
               status_in = sle_pkg::ST_EMPTY;
               value_in  = '0;
               load_out  = (count_ff == '0);
            end
            default: begin
               load_out = 1'b0;
            end
         endcase
      end else if (cmd.dump_step) begin
         status_in   = sle_pkg::ST_OK;
         value_in    = rd_data;
         last_in     = stat.dump_last;
         load_out    = 1'b1;
         dump_idx_in = dump_idx_ff + 1'b1;
      end
      ecount_in = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dump_idx_ff <= '0;
      end else begin
         count_ff    <= count_in;
         dump_idx_ff <= dump_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (load_out) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
         ecount_ff <= ecount_in;
      end
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.dump_last  = (dump_idx_ff == IW'(count_ff - 1'b1));

   assign rsp_status      = status_ff;
   assign rsp_item_value  = value_ff;
   assign rsp_last        = last_ff;
   assign rsp_entry_count = ecount_ff;

endmodule

`default_nettype wire

/* design/sle_ctrl.sv */
// ----------------------------------------------------------------------------
// sle_ctrl
// Handshake controller: accepts items, sequences a dump one entry per cycle
// while the result side is not stalled, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [1:0]           req_op,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sle_pkg::dp_cmd_type  cmd,
   input  wire  sle_pkg::dp_stat_type stat
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free, accept, start_dump, load;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && slot_free && (state_ff == S_IDLE);
   assign start_dump = accept && (req_op == sle_pkg::OP_DUMP) && !stat.count_zero;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.apply     = 1'b0;
      cmd.dump_step = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = slot_free;
            cmd.apply = accept;
            if (start_dump) begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            cmd.dump_step = slot_free;
            if (slot_free && stat.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign load = (cmd.apply && !start_dump) || cmd.dump_step;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
